>>> hdl/lzwd_pkg.sv
// ----------------------------------------------------------------------------
// LZW decoder package
// Shared constants for the LZW code decoder.
// ----------------------------------------------------------------------------
package lzwd_pkg;

	localparam int ALPHABET       = 256;
	localparam int BYTE_W         = 8;
	localparam int DICT_SIZE_DEF  = 4096;
	localparam int MAX_STRING_DEF = 64;

endpackage

>>> hdl/lzwd_ram.sv
// ----------------------------------------------------------------------------
// LZW decoder RAM
// Simple dual-port synchronous RAM with one write port and one registered
// read port.
// ----------------------------------------------------------------------------
module lzwd_ram #(
	parameter int DEPTH = lzwd_pkg::DICT_SIZE_DEF,
	parameter int WIDTH = lzwd_pkg::BYTE_W
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

>>> hdl/lzw_code_decoder.sv
// ----------------------------------------------------------------------------
// LZW code decoder
// Takes one LZW code per transaction and returns its decoded bytes, one byte
// per output transaction in string order, with a flag on the final byte.
// ----------------------------------------------------------------------------
// For each accepted code, the prefix chain is followed through the dictionary
// RAM at one byte per cycle and pushed on a byte stack, and the stack is then
// popped to the output register at one byte per cycle while the output is not
// stalled. A rejected code gives one transaction with bad_code set. The next
// code is taken once the last byte has moved from the stack into the output
// register, where that byte may still wait. At most one dictionary entry is
// written per code and entries are never cleared, so no clearing pass follows
// reset.
module lzw_code_decoder #(
	parameter int DICT_SIZE  = lzwd_pkg::DICT_SIZE_DEF,
	parameter int MAX_STRING = lzwd_pkg::MAX_STRING_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic [$clog2(DICT_SIZE)-1:0] code_in,
	input  logic                         in_valid,
	output logic                         in_stall,
	output logic [lzwd_pkg::BYTE_W-1:0]  out_byte,
	output logic                         last_byte,
	output logic                         bad_code,
	output logic                         out_valid,
	input  logic                         out_stall
);

	localparam int CODE_W = $clog2(DICT_SIZE);
	localparam int NFC_W  = CODE_W + 1;
	localparam int LEN_W  = $clog2(MAX_STRING + 1);
	localparam int SP_AW  = $clog2(MAX_STRING);
	localparam int BYTE_W = lzwd_pkg::BYTE_W;
	localparam int ENT_W  = CODE_W + BYTE_W;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_STEP,
		ST_WAIT,
		ST_EMIT,
		ST_ERR
	} state_t;

	state_t              state_q;
	logic [NFC_W-1:0]    nfc_q;
	logic [CODE_W-1:0]   prev_code_q;
	logic [BYTE_W-1:0]   prev_first_q;
	logic [LEN_W-1:0]    prev_len_q;
	logic                have_prev_q;
	logic [CODE_W-1:0]   code_q;
	logic [CODE_W-1:0]   cur_q;
	logic [LEN_W-1:0]    sp_q;
	logic                pend_q;
	logic                pend_last_q;
	logic                out_valid_q;
	logic [BYTE_W-1:0]   out_byte_q;
	logic                last_q;
	logic                bad_q;

	logic [NFC_W-1:0]    code_ext;
	logic                is_known;
	logic                is_kwk;
	logic                can_add;
	logic                cur_root;
	logic                pfx_root;
	logic                out_free;
	logic                issue;
	logic [LEN_W-1:0]    sp_dec;

	logic                d_we;
	logic                d_re;
	logic [CODE_W-1:0]   d_raddr;
	logic [ENT_W-1:0]    d_rdata;
	logic [CODE_W-1:0]   d_prefix;
	logic [BYTE_W-1:0]   d_last;

	logic                s_we;
	logic [BYTE_W-1:0]   s_wdata;
	logic [BYTE_W-1:0]   s_rdata;

	assign code_ext = {1'b0, code_in};
	assign is_known = code_ext < nfc_q;
	assign can_add  = have_prev_q && (nfc_q < NFC_W'(DICT_SIZE))
			&& (prev_len_q < LEN_W'(MAX_STRING));
	assign is_kwk   = (code_ext == nfc_q) && can_add;

	assign d_prefix = d_rdata[ENT_W-1:BYTE_W];
	assign d_last   = d_rdata[BYTE_W-1:0];
	assign cur_root = cur_q < CODE_W'(lzwd_pkg::ALPHABET);
	assign pfx_root = d_prefix < CODE_W'(lzwd_pkg::ALPHABET);

	assign d_re    = (state_q == ST_STEP) || (state_q == ST_WAIT);
	assign d_raddr = (state_q == ST_WAIT) ? d_prefix : cur_q;
	assign d_we    = (state_q == ST_STEP) && cur_root && can_add;

	assign out_free = !out_valid_q || !out_stall;
	assign issue    = (state_q == ST_EMIT) && (sp_q != '0) && (!pend_q || out_free);
	assign sp_dec   = sp_q - 1'b1;

	always_comb begin
		s_we    = 1'b0;
		s_wdata = d_last;
		unique case (state_q)
			ST_IDLE: begin
				s_we    = in_valid && !is_known && is_kwk;
				s_wdata = prev_first_q;
			end
			ST_STEP: begin
				s_we    = cur_root;
				s_wdata = cur_q[BYTE_W-1:0];
			end
			ST_WAIT: begin
				s_we    = 1'b1;
				s_wdata = d_last;
			end
			default: begin
				s_we    = 1'b0;
				s_wdata = d_last;
			end
		endcase
	end

	lzwd_ram #(
		.DEPTH(DICT_SIZE),
		.WIDTH(ENT_W)
	) u_dict (
		.clk   (clk),
		.we    (d_we),
		.waddr (nfc_q[CODE_W-1:0]),
		.wdata ({prev_code_q, cur_q[BYTE_W-1:0]}),
		.re    (d_re),
		.raddr (d_raddr),
		.rdata (d_rdata)
	);

	lzwd_ram #(
		.DEPTH(MAX_STRING),
		.WIDTH(BYTE_W)
	) u_stack (
		.clk   (clk),
		.we    (s_we),
		.waddr (sp_q[SP_AW-1:0]),
		.wdata (s_wdata),
		.re    (issue),
		.raddr (sp_dec[SP_AW-1:0]),
		.rdata (s_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			nfc_q        <= NFC_W'(lzwd_pkg::ALPHABET);
			prev_code_q  <= '0;
			prev_first_q <= '0;
			prev_len_q   <= '0;
			have_prev_q  <= 1'b0;
			code_q       <= '0;
			cur_q        <= '0;
			sp_q         <= '0;
			pend_q       <= 1'b0;
			pend_last_q  <= 1'b0;
			out_valid_q  <= 1'b0;
			out_byte_q   <= '0;
			last_q       <= 1'b0;
			bad_q        <= 1'b0;
		end else begin
			if (pend_q && out_free) begin
				out_valid_q <= 1'b1;
				out_byte_q  <= s_rdata;
				last_q      <= pend_last_q;
				bad_q       <= 1'b0;
			end else if ((state_q == ST_ERR) && out_free) begin
				out_valid_q <= 1'b1;
				out_byte_q  <= '0;
				last_q      <= 1'b1;
				bad_q       <= 1'b1;
			end else if (out_free) begin
				out_valid_q <= 1'b0;
			end
			if (issue) begin
				pend_q      <= 1'b1;
				pend_last_q <= (sp_q == LEN_W'(1));
			end else if (out_free) begin
				pend_q <= 1'b0;
			end

			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						code_q <= code_in;
						if (is_known) begin
							cur_q   <= code_in;
							sp_q    <= '0;
							state_q <= ST_STEP;
						end else if (is_kwk) begin
							cur_q   <= prev_code_q;
							sp_q    <= LEN_W'(1);
							state_q <= ST_STEP;
						end else begin
							state_q <= ST_ERR;
						end
					end
				end
				ST_STEP: begin
					if (cur_root) begin
						sp_q         <= sp_q + 1'b1;
						if (can_add) begin
							nfc_q <= nfc_q + 1'b1;
						end
						prev_code_q  <= code_q;
						prev_first_q <= cur_q[BYTE_W-1:0];
						prev_len_q   <= sp_q + 1'b1;
						have_prev_q  <= 1'b1;
						state_q      <= ST_EMIT;
					end else begin
						state_q <= ST_WAIT;
					end
				end
				ST_WAIT: begin
					sp_q  <= sp_q + 1'b1;
					cur_q <= d_prefix;
					if (pfx_root) begin
						state_q <= ST_STEP;
					end
				end
				ST_EMIT: begin
					if (issue) begin
						sp_q <= sp_dec;
					end
					if ((sp_q == '0) && (!pend_q || out_free)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_ERR: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign in_stall  = (state_q != ST_IDLE);
	assign out_valid = out_valid_q;
	assign out_byte  = out_byte_q;
	assign last_byte = last_q;
	assign bad_code  = bad_q;

endmodule
